[hw/rtl/etct_pkg.sv]
// Shared types, widths and constants of the elapsed-time text unit.
// No dependencies; every other file of the unit uses this package.
`default_nettype none

package etct_pkg;

  localparam int unsigned TIME_W    = 31;  // elapsed time in ms
  localparam int unsigned DCNT_W    = 4;   // signed digit counts
  localparam int unsigned CAP_W     = 8;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned DIG_W     = 4;
  localparam int unsigned NDIG      = 10;  // HHH MM SS mmm

  localparam int unsigned SECT_W    = 22;  // total seconds
  localparam int unsigned MINT_W    = 16;  // total minutes
  localparam int unsigned HR_W      = 10;
  localparam int unsigned MS_W      = 10;
  localparam int unsigned MN_W      = 6;   // minute / second before saturation
  localparam int unsigned SAT_W     = 7;   // minute / second after saturation

  // reciprocal constants: floor(2^sh / divisor), one correction step after
  localparam int unsigned RCP1_W    = 23;
  localparam int unsigned RCP1_SH   = 32;
  localparam int unsigned RCP2_W    = 23;
  localparam int unsigned RCP2_SH   = 28;
  localparam int unsigned RCP3_W    = 17;
  localparam int unsigned RCP3_SH   = 22;
  localparam logic [RCP1_W-1:0] RCP_1000 = 23'd4294967;
  localparam logic [RCP2_W-1:0] RCP_60S  = 23'd4473924;
  localparam logic [RCP3_W-1:0] RCP_60M  = 17'd69905;

  localparam int unsigned MS_PER_S  = 1000;
  localparam int unsigned SIXTY     = 60;

  localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] ASCII_DOT   = 8'h2E;

  // digit slots of a queue entry
  localparam int unsigned DIG_H2  = 0;
  localparam int unsigned DIG_H1  = 1;
  localparam int unsigned DIG_H0  = 2;
  localparam int unsigned DIG_M1  = 3;
  localparam int unsigned DIG_M0  = 4;
  localparam int unsigned DIG_S1  = 5;
  localparam int unsigned DIG_S0  = 6;
  localparam int unsigned DIG_MS2 = 7;
  localparam int unsigned DIG_MS1 = 8;
  localparam int unsigned DIG_MS0 = 9;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic signed [DCNT_W-1:0] wd;
    logic signed [DCNT_W-1:0] fd;
    logic [CAP_W-1:0]         cap;
  } etct_ctl_t;

  // one classified request, ready to be spelled out
  typedef struct packed {
    logic [NDIG-1:0][DIG_W-1:0] digit;
    logic [LEN_W-1:0]           wl;    // length of the whole part incl. colons
    logic [LEN_W-1:0]           len;   // full text length
    logic                       fits;
    logic                       term;  // terminator follows the text
  } etct_entry_t;

  // x / 100 for x <= 999
  function automatic logic [DIG_W-1:0] div100(input logic [HR_W-1:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd41;
    return p[15:12];
  endfunction

  // x / 10 for x <= 99
  function automatic logic [DIG_W-1:0] div10(input logic [SAT_W-1:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return p[14:11];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/etct_if.sv]
// Request and result channel interfaces of the elapsed-time text unit.
// Depends on etct_pkg for the field widths.
`default_nettype none

interface etct_in_if;
  logic                                valid;
  logic                                ready;
  logic [etct_pkg::TIME_W-1:0]         time_ms;
  logic signed [etct_pkg::DCNT_W-1:0]  whole_digits;
  logic signed [etct_pkg::DCNT_W-1:0]  fraction_digits;
  logic [etct_pkg::CAP_W-1:0]          capacity;

  modport source (output valid, time_ms, whole_digits, fraction_digits, capacity,
                  input ready);
  modport sink   (input valid, time_ms, whole_digits, fraction_digits, capacity,
                  output ready);
endinterface

interface etct_out_if;
  logic                          valid;
  logic                          ready;
  logic [etct_pkg::CHAR_W-1:0]   text_char;
  logic [etct_pkg::POS_W-1:0]    char_position;
  logic [etct_pkg::LEN_W-1:0]    text_length;
  logic                          fits;
  logic                          last;

  modport source (output valid, text_char, char_position, text_length, fits, last,
                  input ready);
  modport sink   (input valid, text_char, char_position, text_length, fits, last,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/elapsed_time_to_clock_text_unit.sv]
// Elapsed time (ms) to H:MM:SS.mmm text; uses etct_pkg, etct_if, front, queue, back.
// Path: front pipeline, queue, back end's entry register, then the output register.
// Throughput: front takes one request per cycle unless stalled by a full queue;
// back sends one character per cycle while ready; a request yields 1 to 14 chars.
// Reset: synchronous active-low rst_n empties pipeline, queue and output register.
`default_nettype none

module elapsed_time_to_clock_text_unit #(
  parameter int unsigned QUEUE_DEPTH = etct_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  etct_in_if.sink    in_ch,
  etct_out_if.source out_ch
);
  import etct_pkg::*;

  // Front: reciprocal-multiply pipeline (ms -> s -> min -> h), each multiply
  // followed by a one-step correction, then digit-count resolution and BCD.
  // The front stalls as a whole only when its last stage cannot enter the queue.
  logic        f_valid, f_ready;
  etct_entry_t f_ent;

  etct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .ent_valid (f_valid),
    .ent_ready (f_ready),
    .ent       (f_ent)
  );

  // Queue decouples the fixed-rate front from the variable-length back end.
  logic        q_valid, q_ready;
  etct_entry_t q_ent;

  etct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_ent),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_ent)
  );

  // Back: walks character positions of one entry; picks up the next entry in
  // the same cycle as the current one's last character, so no gap between texts.
  etct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (q_valid),
    .ent_ready (q_ready),
    .ent       (q_ent),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[hw/rtl/etct_front.sv]
// Front end: splits the time into h/m/s/ms, resolves digit counts, builds digits.
// Nine-stage pipeline with a common stall; depends on etct_pkg and etct_if.
`default_nettype none

module etct_front (
  input  logic                  clk,
  input  logic                  rst_n,
  etct_in_if.sink               in_ch,
  output logic                  ent_valid,
  input  logic                  ent_ready,
  output etct_pkg::etct_entry_t ent
);
  import etct_pkg::*;

  localparam int unsigned NSTG = 9;

  logic [NSTG-1:0] v_r;
  logic            en;
  etct_ctl_t       ctl_r [6];
  etct_ctl_t       ctl_nxt;

  assign en          = !(v_r[NSTG-1] && !ent_ready);
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_ch.valid};
    end
  end

  assign ctl_nxt = '{wd: in_ch.whole_digits, fd: in_ch.fraction_digits,
                     cap: in_ch.capacity};

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= ctl_nxt;
      for (int i = 1; i < 6; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  // stage 1: seconds estimate
  logic [TIME_W+RCP1_W-1:0] p1;
  logic [TIME_W-1:0]        t1_r;
  logic [SECT_W-1:0]        q1_r, q1_nxt;
  assign p1     = (TIME_W+RCP1_W)'(in_ch.time_ms) * (TIME_W+RCP1_W)'(RCP_1000);
  assign q1_nxt = p1[RCP1_SH +: SECT_W];

  // stage 2: correct, milliseconds
  logic [31:0]         diff2;
  logic [10:0]         r2;
  logic                corr2;
  logic [SECT_W-1:0]   sect2_r, sect2_nxt;
  logic [MS_W-1:0]     ms2_r, ms2_nxt;
  assign diff2     = {1'b0, t1_r} - 32'(q1_r) * 32'(MS_PER_S);
  assign r2        = diff2[10:0];
  assign corr2     = r2 >= 11'(MS_PER_S);
  assign sect2_nxt = q1_r + SECT_W'(corr2);
  assign ms2_nxt   = corr2 ? MS_W'(r2 - 11'(MS_PER_S)) : MS_W'(r2);

  // stage 3: minutes estimate
  logic [SECT_W+RCP2_W-1:0] p3;
  logic [MINT_W-1:0]        q3_r, q3_nxt;
  logic [SECT_W-1:0]        sect3_r;
  logic [MS_W-1:0]          ms3_r;
  assign p3     = (SECT_W+RCP2_W)'(sect2_r) * (SECT_W+RCP2_W)'(RCP_60S);
  assign q3_nxt = p3[RCP2_SH +: MINT_W];

  // stage 4: correct, seconds
  logic [SECT_W-1:0]   diff4;
  logic [6:0]          r4;
  logic                corr4;
  logic [MINT_W-1:0]   mint4_r, mint4_nxt;
  logic [MN_W-1:0]     sec4_r, sec4_nxt;
  logic [MS_W-1:0]     ms4_r;
  assign diff4     = sect3_r - SECT_W'(q3_r) * SECT_W'(SIXTY);
  assign r4        = diff4[6:0];
  assign corr4     = r4 >= 7'(SIXTY);
  assign mint4_nxt = q3_r + MINT_W'(corr4);
  assign sec4_nxt  = corr4 ? MN_W'(r4 - 7'(SIXTY)) : MN_W'(r4);

  // stage 5: hours estimate
  logic [MINT_W+RCP3_W-1:0] p5;
  logic [HR_W-1:0]          q5_r, q5_nxt;
  logic [MINT_W-1:0]        mint5_r;
  logic [MN_W-1:0]          sec5_r;
  logic [MS_W-1:0]          ms5_r;
  assign p5     = (MINT_W+RCP3_W)'(mint4_r) * (MINT_W+RCP3_W)'(RCP_60M);
  assign q5_nxt = p5[RCP3_SH +: HR_W];

  // stage 6: correct, minutes
  logic [MINT_W-1:0]   diff6;
  logic [6:0]          r6;
  logic                corr6;
  logic [HR_W-1:0]     hr6_r, hr6_nxt;
  logic [MN_W-1:0]     mn6_r, mn6_nxt;
  logic [MN_W-1:0]     sec6_r;
  logic [MS_W-1:0]     ms6_r;
  assign diff6   = mint5_r - MINT_W'(q5_r) * MINT_W'(SIXTY);
  assign r6      = diff6[6:0];
  assign corr6   = r6 >= 7'(SIXTY);
  assign hr6_nxt = q5_r + HR_W'(corr6);
  assign mn6_nxt = corr6 ? MN_W'(r6 - 7'(SIXTY)) : MN_W'(r6);

  // stage 7: digit counts, overflow, lengths
  logic signed [DCNT_W-1:0] wd_in, fd_in;
  logic [DCNT_W-1:0]        mag;
  logic [2:0]               lim, auto_wd, wd_e;
  logic [1:0]               fd_e;
  logic                     over;
  logic [HR_W-1:0]          hr7_r, hr7_nxt;
  logic [SAT_W-1:0]         mn7_r, mn7_nxt, sec7_r, sec7_nxt;
  logic [MS_W-1:0]          ms7_r, ms7_nxt;
  logic [LEN_W-1:0]         wl7_r, wl7_nxt, len7_r, len7_nxt;
  logic                     fits7_r, fits7_nxt, term7_r, term7_nxt;

  always_comb begin
    wd_in = ctl_r[5].wd;
    fd_in = ctl_r[5].fd;
    mag   = DCNT_W'(-wd_in);
    lim   = (mag > 4'd7) ? 3'd7 : mag[2:0];
    if (hr6_r >= 10'd100)     auto_wd = 3'd7;
    else if (hr6_r >= 10'd10) auto_wd = 3'd6;
    else if (hr6_r != '0)     auto_wd = 3'd5;
    else if (mn6_r >= 6'd10)  auto_wd = 3'd4;
    else if (mn6_r != '0)     auto_wd = 3'd3;
    else if (sec6_r >= 6'd10) auto_wd = 3'd2;
    else                      auto_wd = 3'd1;

    if (wd_in < 0)       wd_e = (auto_wd > lim) ? lim : auto_wd;
    else if (wd_in == 0) wd_e = 3'd1;
    else                 wd_e = wd_in[2:0];

    if (fd_in < 0)            fd_e = 2'd0;
    else if (fd_in > 4'sd3)   fd_e = 2'd3;
    else                      fd_e = fd_in[1:0];

    // only the leading unit shown is range-checked
    case (wd_e)
      3'd7:    over = hr6_r > 10'd999;
      3'd6:    over = hr6_r > 10'd99;
      3'd5:    over = hr6_r > 10'd9;
      3'd4:    over = 7'(mn6_r) > 7'd99;
      3'd3:    over = mn6_r > 6'd9;
      3'd2:    over = 7'(sec6_r) > 7'd99;
      default: over = sec6_r > 6'd9;
    endcase

    hr7_nxt  = over ? 10'd999 : hr6_r;
    ms7_nxt  = over ? 10'd999 : ms6_r;
    mn7_nxt  = over ? 7'd99 : SAT_W'(mn6_r);
    sec7_nxt = over ? 7'd99 : SAT_W'(sec6_r);

    wl7_nxt   = LEN_W'(wd_e) + LEN_W'(wd_e >= 3'd3) + LEN_W'(wd_e >= 3'd5);
    len7_nxt  = wl7_nxt + LEN_W'(fd_e) + LEN_W'(fd_e != 2'd0);
    fits7_nxt = CAP_W'(len7_nxt) <= ctl_r[5].cap;
    term7_nxt = CAP_W'(len7_nxt) < ctl_r[5].cap;
  end

  // stage 8: hundreds and tens splits
  logic [DIG_W-1:0] h2_8_r, h2_8_nxt, ms2_8_r, ms2_8_nxt;
  logic [SAT_W-1:0] hlo8_r, hlo8_nxt, mslo8_r, mslo8_nxt;
  logic [DIG_W-1:0] m1_8_r, m1_8_nxt, m0_8_r, m0_8_nxt;
  logic [DIG_W-1:0] s1_8_r, s1_8_nxt, s0_8_r, s0_8_nxt;
  logic [LEN_W-1:0] wl8_r, len8_r;
  logic             fits8_r, term8_r;

  always_comb begin
    h2_8_nxt  = div100(hr7_r);
    hlo8_nxt  = SAT_W'(hr7_r - HR_W'(h2_8_nxt) * 10'd100);
    ms2_8_nxt = div100(ms7_r);
    mslo8_nxt = SAT_W'(ms7_r - MS_W'(ms2_8_nxt) * 10'd100);
    m1_8_nxt  = div10(mn7_r);
    m0_8_nxt  = DIG_W'(mn7_r - SAT_W'(m1_8_nxt) * 7'd10);
    s1_8_nxt  = div10(sec7_r);
    s0_8_nxt  = DIG_W'(sec7_r - SAT_W'(s1_8_nxt) * 7'd10);
  end

  // stage 9: last tens splits, entry register
  logic [DIG_W-1:0] h1_nxt, h0_nxt, ms1_nxt, ms0_nxt;
  etct_entry_t      ent_r, ent_nxt;

  always_comb begin
    h1_nxt  = div10(hlo8_r);
    h0_nxt  = DIG_W'(hlo8_r - SAT_W'(h1_nxt) * 7'd10);
    ms1_nxt = div10(mslo8_r);
    ms0_nxt = DIG_W'(mslo8_r - SAT_W'(ms1_nxt) * 7'd10);
    ent_nxt                 = '0;
    ent_nxt.digit[DIG_H2]   = h2_8_r;
    ent_nxt.digit[DIG_H1]   = h1_nxt;
    ent_nxt.digit[DIG_H0]   = h0_nxt;
    ent_nxt.digit[DIG_M1]   = m1_8_r;
    ent_nxt.digit[DIG_M0]   = m0_8_r;
    ent_nxt.digit[DIG_S1]   = s1_8_r;
    ent_nxt.digit[DIG_S0]   = s0_8_r;
    ent_nxt.digit[DIG_MS2]  = ms2_8_r;
    ent_nxt.digit[DIG_MS1]  = ms1_nxt;
    ent_nxt.digit[DIG_MS0]  = ms0_nxt;
    ent_nxt.wl              = wl8_r;
    ent_nxt.len             = len8_r;
    ent_nxt.fits            = fits8_r;
    ent_nxt.term            = term8_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r    <= in_ch.time_ms;
      q1_r    <= q1_nxt;
      sect2_r <= sect2_nxt;
      ms2_r   <= ms2_nxt;
      q3_r    <= q3_nxt;
      sect3_r <= sect2_r;
      ms3_r   <= ms2_r;
      mint4_r <= mint4_nxt;
      sec4_r  <= sec4_nxt;
      ms4_r   <= ms3_r;
      q5_r    <= q5_nxt;
      mint5_r <= mint4_r;
      sec5_r  <= sec4_r;
      ms5_r   <= ms4_r;
      hr6_r   <= hr6_nxt;
      mn6_r   <= mn6_nxt;
      sec6_r  <= sec5_r;
      ms6_r   <= ms5_r;
      hr7_r   <= hr7_nxt;
      mn7_r   <= mn7_nxt;
      sec7_r  <= sec7_nxt;
      ms7_r   <= ms7_nxt;
      wl7_r   <= wl7_nxt;
      len7_r  <= len7_nxt;
      fits7_r <= fits7_nxt;
      term7_r <= term7_nxt;
      h2_8_r  <= h2_8_nxt;
      hlo8_r  <= hlo8_nxt;
      ms2_8_r <= ms2_8_nxt;
      mslo8_r <= mslo8_nxt;
      m1_8_r  <= m1_8_nxt;
      m0_8_r  <= m0_8_nxt;
      s1_8_r  <= s1_8_nxt;
      s0_8_r  <= s0_8_nxt;
      wl8_r   <= wl7_r;
      len8_r  <= len7_r;
      fits8_r <= fits7_r;
      term8_r <= term7_r;
      ent_r   <= ent_nxt;
    end
  end

  assign ent_valid = v_r[NSTG-1];
  assign ent       = ent_r;

`ifndef SYNTHESIS
  // a held entry must not move while the queue pushes back
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ent_valid && !ent_ready |=> ent_valid && $stable(ent))
    else $error("front entry changed while stalled");
`endif

endmodule

`default_nettype wire

[hw/rtl/etct_queue.sv]
// Short entry queue between the front and back ends of the text unit.
// Flop storage, one write and one read port; depends on etct_pkg.
`default_nettype none

module etct_queue #(
  parameter int unsigned DEPTH = etct_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  etct_pkg::etct_entry_t wr_data,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output etct_pkg::etct_entry_t rd_data
);
  import etct_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  etct_entry_t   mem_r [DEPTH];
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push, pop;

  assign wr_ready = cnt_r != CW'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[head_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (pop)  head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
    if (push) tail_nxt = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + AW'(1);
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("queue count missed a write");
`endif

endmodule

`default_nettype wire

[hw/rtl/etct_back.sv]
// Back end: spells one queue entry out as characters into an output register.
// Depends on etct_pkg and etct_if.
`default_nettype none

module etct_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ent_valid,
  output logic                  ent_ready,
  input  etct_pkg::etct_entry_t ent,
  etct_out_if.source            out_ch
);
  import etct_pkg::*;

  // character slots of the full whole part "HHH:MM:SS"
  localparam logic [POS_W-1:0] SL_H2 = 4'd0;
  localparam logic [POS_W-1:0] SL_H1 = 4'd1;
  localparam logic [POS_W-1:0] SL_H0 = 4'd2;
  localparam logic [POS_W-1:0] SL_C1 = 4'd3;
  localparam logic [POS_W-1:0] SL_M1 = 4'd4;
  localparam logic [POS_W-1:0] SL_M0 = 4'd5;
  localparam logic [POS_W-1:0] SL_C2 = 4'd6;
  localparam logic [POS_W-1:0] SL_S1 = 4'd7;
  localparam logic [POS_W-1:0] SL_S0 = 4'd8;
  localparam logic [POS_W-1:0] SL_END = 4'd9;
  // slots of the fraction part ".mmm"
  localparam logic [POS_W-1:0] FR_DOT = 4'd0;
  localparam logic [POS_W-1:0] FR_D2  = 4'd1;
  localparam logic [POS_W-1:0] FR_D1  = 4'd2;
  localparam logic [POS_W-1:0] FR_D0  = 4'd3;

  etct_entry_t       cur_r, cur_nxt;
  logic              busy_r, busy_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic [POS_W-1:0]  opos_r;
  logic [LEN_W-1:0]  len_r;
  logic              fits_r, last_r;

  logic              out_free, emit, cur_last, load;
  logic [POS_W-1:0]  slot, frac;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign emit      = busy_r && out_free;
  assign cur_last  = !cur_r.fits ||
                     (cur_r.term ? (pos_r == cur_r.len) : (pos_r == cur_r.len - LEN_W'(1)));
  assign ent_ready = !busy_r || (emit && cur_last);
  assign load      = ent_valid && ent_ready;

  always_comb begin
    slot     = SL_END - cur_r.wl + pos_r;
    frac     = pos_r - cur_r.wl;
    char_nxt = ASCII_NUL;
    if (!cur_r.fits || pos_r >= cur_r.len) begin
      char_nxt = ASCII_NUL;
    end else if (pos_r < cur_r.wl) begin
      case (slot)
        SL_H2:   char_nxt = ASCII_ZERO + CHAR_W'(cur_r.digit[DIG_H2]);
        SL_H1:   char_nxt = ASCII_ZERO + CHAR_W'(cur_r.digit[DIG_H1]);
        SL_H0:   char_nxt = ASCII_ZERO + CHAR_W'(cur_r.digit[DIG_H0]);
        SL_C1:   char_nxt = ASCII_COLON;
        SL_M1:   char_nxt = ASCII_ZERO + CHAR_W'(cur_r.digit[DIG_M1]);
        SL_M0:   char_nxt = ASCII_ZERO + CHAR_W'(cur_r.digit[DIG_M0]);
        SL_C2:   char_nxt = ASCII_COLON;
        SL_S1:   char_nxt = ASCII_ZERO + CHAR_W'(cur_r.digit[DIG_S1]);
        SL_S0:   char_nxt = ASCII_ZERO + CHAR_W'(cur_r.digit[DIG_S0]);
        default: char_nxt = ASCII_NUL;
      endcase
    end else begin
      case (frac)
        FR_DOT:  char_nxt = ASCII_DOT;
        FR_D2:   char_nxt = ASCII_ZERO + CHAR_W'(cur_r.digit[DIG_MS2]);
        FR_D1:   char_nxt = ASCII_ZERO + CHAR_W'(cur_r.digit[DIG_MS1]);
        FR_D0:   char_nxt = ASCII_ZERO + CHAR_W'(cur_r.digit[DIG_MS0]);
        default: char_nxt = ASCII_NUL;
      endcase
    end
  end

  always_comb begin
    cur_nxt  = load ? ent : cur_r;
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    if (load) begin
      busy_nxt = 1'b1;
      pos_nxt  = '0;
    end else if (emit) begin
      busy_nxt = !cur_last;
      pos_nxt  = pos_r + POS_W'(1);
    end
    out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      char_r <= char_nxt;
      opos_r <= cur_r.fits ? pos_r : '0;
      len_r  <= cur_r.len;
      fits_r <= cur_r.fits;
      last_r <= cur_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.text_char     = char_r;
  assign out_ch.char_position = opos_r;
  assign out_ch.text_length   = len_r;
  assign out_ch.fits          = fits_r;
  assign out_ch.last          = last_r;

`ifndef SYNTHESIS
  a_nofit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !fits_r |-> last_r && char_r == ASCII_NUL && opos_r == '0)
    else $error("no-room result malformed");
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cur_r.fits |-> pos_r <= cur_r.len)
    else $error("character position ran past the text");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && fits_r && last_r |->
      (opos_r == len_r) || (POS_W'(opos_r + POS_W'(1)) == len_r))
    else $error("last flag on a wrong position");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for elapsed_time_to_clock_text_unit: a scoreboard class
// predicts each request's characters and checks the result stream.
// Depends on etct_pkg, etct_if and the unit itself.
`timescale 1ns / 100ps

module testbench;
  import etct_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic              fits;
    logic              last;
  } clock_char_t;

  class clock_text_board;
    clock_char_t awaited_chars[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return awaited_chars.size();
    endfunction

    function logic [CHAR_W-1:0] digit_char(int unsigned v);
      return ASCII_ZERO + CHAR_W'(v % 10);
    endfunction

    function void push_char(logic [CHAR_W-1:0] ch, int unsigned pos, int unsigned len,
                            bit fits, bit last);
      clock_char_t c;
      c.ch   = ch;
      c.pos  = POS_W'(pos);
      c.len  = LEN_W'(len);
      c.fits = fits;
      c.last = last;
      awaited_chars.push_back(c);
    endfunction

    // Spell out one accepted request as the characters it should produce
    function void note_request(logic [TIME_W-1:0] t, logic signed [DCNT_W-1:0] wd_in,
                               logic signed [DCNT_W-1:0] fd_in, logic [CAP_W-1:0] cap);
      int unsigned ms, sec, mn, hr, len, p;
      int wd, fd, lim;
      bit over, term;
      logic [CHAR_W-1:0] txt[16];
      ms  = t % MS_PER_S;
      sec = t / MS_PER_S;
      mn  = sec / SIXTY;
      hr  = mn / SIXTY;
      sec = sec % SIXTY;
      mn  = mn % SIXTY;

      fd = fd_in;
      if (fd < 0) fd = 0;
      else if (fd > 3) fd = 3;

      wd = wd_in;
      if (wd < 0) begin
        // automatic width from the largest nonzero unit, capped by the magnitude
        lim = -wd;
        if (lim > 7) lim = 7;
        if (hr >= 100) wd = 7;
        else if (hr >= 10) wd = 6;
        else if (hr >= 1) wd = 5;
        else if (mn >= 10) wd = 4;
        else if (mn >= 1) wd = 3;
        else if (sec >= 10) wd = 2;
        else wd = 1;
        if (wd > lim) wd = lim;
      end
      if (wd < 1) wd = 1;

      case (wd)
        7: over = hr > 999;
        6: over = hr > 99;
        5: over = hr > 9;
        4: over = mn > 99;
        3: over = mn > 9;
        2: over = sec > 99;
        default: over = sec > 9;
      endcase
      if (over) begin
        hr  = 999;
        ms  = 999;
        mn  = 99;
        sec = 99;
      end

      len = wd + fd + (fd != 0) + (wd >= 3) + (wd >= 5);
      if (len > cap) begin
        push_char(ASCII_NUL, 0, len, 1'b0, 1'b1);
        return;
      end

      p = 0;
      if (wd >= 7) txt[p++] = digit_char(hr / 100);
      if (wd >= 6) txt[p++] = digit_char(hr / 10);
      if (wd >= 5) begin
        txt[p++] = digit_char(hr);
        txt[p++] = ASCII_COLON;
      end
      if (wd >= 4) txt[p++] = digit_char(mn / 10);
      if (wd >= 3) begin
        txt[p++] = digit_char(mn);
        txt[p++] = ASCII_COLON;
      end
      if (wd >= 2) txt[p++] = digit_char(sec / 10);
      txt[p++] = digit_char(sec);
      if (fd != 0) begin
        txt[p++] = ASCII_DOT;
        txt[p++] = digit_char(ms / 100);
        if (fd >= 2) txt[p++] = digit_char(ms / 10);
        if (fd >= 3) txt[p++] = digit_char(ms);
      end

      term = len < cap;
      for (int unsigned i = 0; i < p; i++)
        push_char(txt[i], i, len, 1'b1, !term && (i + 1 == p));
      if (term) push_char(ASCII_NUL, len, len, 1'b1, 1'b1);
    endfunction

    function void check_char(clock_char_t got);
      clock_char_t want;
      if (awaited_chars.size() == 0) begin
        $error("unexpected character %0d at position %0d, no request pending",
               got.ch, got.pos);
        mismatches++;
        return;
      end
      want = awaited_chars.pop_front();
      if (got.ch !== want.ch) begin
        $error("text_char: expected %0d, got %0d", want.ch, got.ch);
        mismatches++;
      end
      if (got.pos !== want.pos) begin
        $error("char_position: expected %0d, got %0d", want.pos, got.pos);
        mismatches++;
      end
      if (got.len !== want.len) begin
        $error("text_length: expected %0d, got %0d", want.len, got.len);
        mismatches++;
      end
      if (got.fits !== want.fits) begin
        $error("fits: expected %0d, got %0d", want.fits, got.fits);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  etct_in_if  in_ch ();
  etct_out_if out_ch ();

  elapsed_time_to_clock_text_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  clock_text_board board = new();

  // Idling controls, percent of cycles; hold_left is a long receiver hold-off,
  // counted down by the receiver process itself
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("testbench: errors");
    $finish;
  end

  // Result side: take what the edge accepted (pre-edge values), then pick
  // the ready level for the next cycle
  initial begin
    clock_char_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.ch   = out_ch.text_char;
        got.pos  = out_ch.char_position;
        got.len  = out_ch.text_length;
        got.fits = out_ch.fits;
        got.last = out_ch.last;
        board.check_char(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one request, idling first at random; returns on the accepting edge
  task automatic send_request(input logic [TIME_W-1:0] t, input logic [DCNT_W-1:0] wd,
                              input logic [DCNT_W-1:0] fd, input logic [CAP_W-1:0] cap);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.time_ms         <= t;
    in_ch.whole_digits    <= wd;
    in_ch.fraction_digits <= fd;
    in_ch.capacity        <= cap;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_request(t, wd, fd, cap);
  endtask

  // Random request: times spread over seconds, minutes, hours and the full
  // range; capacities mostly around the text lengths so all three endings show
  task automatic send_random_requests(input int unsigned count);
    logic [TIME_W-1:0] t;
    logic [CAP_W-1:0]  cap;
    repeat (count) begin
      case ($urandom_range(3))
        0: t = TIME_W'($urandom_range(59999));
        1: t = TIME_W'($urandom_range(3599999));
        2: t = TIME_W'($urandom_range(359999999));
        default: t = TIME_W'($urandom);
      endcase
      case ($urandom_range(3))
        0, 1: cap = CAP_W'($urandom_range(14));
        2: cap = CAP_W'($urandom);
        default: cap = 8'hFF;
      endcase
      send_request(t, DCNT_W'($urandom_range(15)), DCNT_W'($urandom_range(15)), cap);
    end
  endtask

  // Stop offering and wait for every predicted character, then let the
  // pipeline settle so a stray extra result would still be caught
  task automatic wait_for_drain(input int unsigned settle);
    in_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    in_ch.valid           <= 1'b0;
    in_ch.time_ms         <= '0;
    in_ch.whole_digits    <= '0;
    in_ch.fraction_digits <= '0;
    in_ch.capacity        <= '0;
    rst_n                 <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests, no idling
    send_request(31'd0, 4'sd1, 4'sd0, 8'd255);              // shortest text
    send_request(31'h7FFFFFFF, 4'sd7, 4'sd3, 8'd255);       // largest time
    send_request(31'h7FFFFFFF, -4'sd8, 4'sd7, 8'd13);       // auto, exact fit
    send_request(31'h7FFFFFFF, -4'sd8, -4'sd8, 8'd0);       // no room
    send_request(31'd59999, 4'sd0, 4'sd2, 8'd255);          // zero whole, overflow
    send_request(31'd9999, -4'sd1, 4'sd1, 8'd4);            // auto one digit
    send_request(31'd12345, -4'sd7, 4'sd3, 8'd6);           // auto seconds, exact fit
    send_request(31'd61000, -4'sd7, 4'sd0, 8'd255);         // auto single minute
    send_request(31'd600000, -4'sd7, 4'sd0, 8'd255);        // auto tens of minutes
    send_request(31'd600000, 4'sd3, 4'sd0, 8'd255);         // minute overflow
    send_request(31'd3600000, -4'sd7, 4'sd3, 8'd255);       // auto single hour
    send_request(31'd36000000, -4'sd7, 4'sd1, 8'd255);      // auto tens of hours
    send_request(31'd360000000, -4'sd7, 4'sd2, 8'd255);     // auto hundreds of hours
    send_request(31'd36000000, 4'sd5, 4'sd3, 8'd255);       // hour overflow, 5 digits
    send_request(31'd360000000, 4'sd6, 4'sd3, 8'd255);      // hour overflow, 6 digits
    send_request(31'd360000000, -4'sd3, 4'sd0, 8'd255);     // auto capped by limit
    send_request(31'd3723004, 4'sd4, 4'sd3, 8'd255);        // higher units dropped
    send_request(31'd3723004, 4'sd2, -4'sd1, 8'd1);         // fraction clamp, no room
    send_request(31'd3723004, 4'sd7, 4'sd4, 8'd14);         // fraction clamp high
    send_request(31'd999, 4'sd1, 4'sd3, 8'd5);              // exact fit
    send_request(31'd1000, -4'sd2, 4'sd3, 8'd0);            // zero capacity
    send_request(31'd86399999, 4'sd6, 4'sd2, 8'd255);       // last ms of a day

    // Random requests over the idling phases
    send_random_requests(60);

    send_idle_pct = 74;
    send_random_requests(50);
    wait_for_drain(20);

    send_idle_pct  = 0;
    recv_stall_pct = 74;
    send_random_requests(50);

    send_idle_pct  = 14;
    recv_stall_pct = 14;
    send_random_requests(50);

    // Receiver holds off while requests keep coming: the queue fills and
    // the request side must stall
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 400;
    send_random_requests(40);

    wait_for_drain(40);
    if (board.mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end
endmodule
